/* design/kft_pkg.sv */
package kft_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW          = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int TOT_W   = 36;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;

    typedef logic [CMD_W-1:0]         t_cmd;
    typedef logic [STAT_W-1:0]        t_status;
    typedef logic signed [KEY_W-1:0]  t_key;
    typedef logic [VAL_W-1:0]         t_val;
    typedef logic [TOT_W-1:0]         t_total;
    typedef logic [AW-1:0]            t_slot;
    typedef logic [CW-1:0]            t_count;

    // Command codes
    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_REMOVE = 2'd1;
    localparam t_cmd CMD_SEARCH = 2'd2;
    localparam t_cmd CMD_LIST   = 2'd3;

    // Status codes
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_DUP      = 3'd1;
    localparam t_status ST_FULL     = 3'd2;
    localparam t_status ST_EMPTY    = 3'd3;
    localparam t_status ST_NOTFOUND = 3'd4;

    // Store write port
    typedef struct packed {
        logic  we;
        t_slot addr;
        t_key  key;
        t_val  value;
    } t_wr;

    // Store read port
    typedef struct packed {
        logic  re;
        t_slot addr;
    } t_rd;

    // Slot that lies 'back' places before 'newest', modulo the depth
    function automatic t_slot slot_back(t_slot newest, t_slot back);
        logic [AW:0] sum;
        sum = {1'b0, newest} + (AW+1)'(TABLE_DEPTH) - {1'b0, back};
        if (sum >= (AW+1)'(TABLE_DEPTH)) begin
            sum = sum - (AW+1)'(TABLE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Next slot after 'slot', wrapping at the depth
    function automatic t_slot slot_next(t_slot slot);
        t_slot res;
        if (slot == t_slot'(TABLE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = slot + t_slot'(1);
        end
        return res;
    endfunction

endpackage

/* design/kft_ifs.sv */
// Command channel
interface kft_in_if import kft_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd command;
    t_key key;
    t_val value_cents;

    modport source (output valid, command, key, value_cents, input ready);
    modport sink   (input valid, command, key, value_cents, output ready);
endinterface

// Result channel
interface kft_out_if import kft_pkg::*; ();
    logic    valid;
    logic    ready;
    t_status status;
    t_key    out_key;
    t_val    out_value;
    t_total  running_total;
    logic    last;

    modport source (output valid, status, out_key, out_value, running_total, last,
                     input ready);
    modport sink   (input valid, status, out_key, out_value, running_total, last,
                    output ready);
endinterface

/* design/kft_store.sv */
// Record store: one write port, one read port, registered read data
module kft_store import kft_pkg::*; (
    input  logic i_clk,
    input  t_wr  i_wr,
    input  t_rd  i_rd,
    output t_key o_rkey,
    output t_val o_rval
);

    t_key mem_key [TABLE_DEPTH];
    t_val mem_val [TABLE_DEPTH];
    t_key r_rkey;
    t_val r_rval;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem_key[i_wr.addr] <= i_wr.key;
            mem_val[i_wr.addr] <= i_wr.value;
        end
    end

    // Read port, data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd.re) begin
            r_rkey <= mem_key[i_rd.addr];
            r_rval <= mem_val[i_rd.addr];
        end
    end

    assign o_rkey = r_rkey;
    assign o_rval = r_rval;

endmodule

/* design/keyed_fifo_table.sv */
// Remove, and any command on an empty table, loads its result from S_ONE or S_INS once
// the result register is free. Search walks the stored records newest first, one read a
// cycle through the store's single read port while the result register is free or taken;
// insert walks the same way for a duplicate, then writes in S_INS; list loads one beat per
// record, one beat a cycle while the result side takes them. One command at a time.
// Reset (synchronous, active low) empties the table; store contents stay undefined.
module keyed_fifo_table import kft_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    kft_in_if.sink   i_cmd,
    kft_out_if.source o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;
    localparam logic [1:0] S_ONE  = 2'd3;

    // Control state
    logic [1:0] r_state, n_state;
    t_count     r_count, n_count;
    t_slot      r_newest, n_newest;
    t_count     r_iss, n_iss;
    t_count     r_ci, n_ci;
    logic       r_pend, n_pend;
    logic       r_ovalid, n_ovalid;

    // Command payload and walk data
    t_cmd    r_cmd, n_cmd;
    t_key    r_key, n_key;
    t_val    r_val, n_val;
    t_total  r_total, n_total;
    t_status r_st, n_st;

    // Result register
    t_status r_ost;
    t_key    r_okey;
    t_val    r_oval;
    t_total  r_otot;
    logic    r_olast;

    // Result to load
    logic    em_valid;
    t_status em_status;
    t_key    em_key;
    t_val    em_val;
    t_total  em_tot;
    logic    em_last;

    t_wr  wr;
    t_rd  rd;
    t_key rkey;
    t_val rval;

    logic   out_free;
    logic   consume;
    logic   issue;
    logic   at_last;
    t_total sum;

    kft_store u_store (
        .i_clk  (i_clk),
        .i_wr   (wr),
        .i_rd   (rd),
        .o_rkey (rkey),
        .o_rval (rval)
    );

    assign out_free = !r_ovalid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign consume = (r_state == S_WALK) && r_pend && out_free;
    assign issue = (r_state == S_WALK) && (r_iss < r_count) && (!r_pend || consume);
    assign at_last = ((r_ci + t_count'(1)) == r_count);
    assign sum = r_total + t_total'(rval);

    // Command sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_newest = r_newest;
        n_iss    = r_iss;
        n_ci     = r_ci;
        n_pend   = r_pend;
        n_cmd    = r_cmd;
        n_key    = r_key;
        n_val    = r_val;
        n_total  = r_total;
        n_st     = r_st;

        em_valid  = 1'b0;
        em_status = ST_OK;
        em_key    = '0;
        em_val    = '0;
        em_tot    = '0;
        em_last   = 1'b1;

        wr.we    = 1'b0;
        wr.addr  = slot_next(r_newest);
        wr.key   = r_key;
        wr.value = r_val;
        rd.re    = issue;
        rd.addr  = slot_back(r_newest, r_iss[AW-1:0]);

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd   = i_cmd.command;
                    n_key   = i_cmd.key;
                    n_val   = i_cmd.value_cents;
                    n_iss   = '0;
                    n_ci    = '0;
                    n_pend  = 1'b0;
                    n_total = '0;
                    if (r_count == '0) begin
                        unique case (i_cmd.command)
                            CMD_INSERT: n_state = S_INS;
                            CMD_SEARCH: begin
                                n_st    = ST_NOTFOUND;
                                n_state = S_ONE;
                            end
                            default: begin
                                n_st    = ST_EMPTY;
                                n_state = S_ONE;
                            end
                        endcase
                    end else if (i_cmd.command == CMD_REMOVE) begin
                        n_count = r_count - t_count'(1);
                        n_st    = ST_OK;
                        n_state = S_ONE;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end

            S_WALK: begin
                if (issue) begin
                    n_iss  = r_iss + t_count'(1);
                    n_ci   = r_iss;
                    n_pend = 1'b1;
                end else if (consume) begin
                    n_pend = 1'b0;
                end
                if (consume) begin
                    priority case (r_cmd)
                        CMD_LIST: begin
                            em_valid  = 1'b1;
                            em_key    = rkey;
                            em_val    = rval;
                            em_tot    = sum;
                            em_last   = at_last;
                            n_total   = sum;
                            if (at_last) begin
                                n_state = S_IDLE;
                            end
                        end
                        CMD_SEARCH: begin
                            if (rkey == r_key) begin
                                em_valid = 1'b1;
                                em_key   = rkey;
                                em_val   = rval;
                                n_state  = S_IDLE;
                            end else if (at_last) begin
                                em_valid  = 1'b1;
                                em_status = ST_NOTFOUND;
                                n_state   = S_IDLE;
                            end
                        end
                        default: begin
                            // insert: duplicate check
                            if (rkey == r_key) begin
                                em_valid  = 1'b1;
                                em_status = ST_DUP;
                                n_state   = S_IDLE;
                            end else if (at_last) begin
                                n_state = S_INS;
                            end
                        end
                    endcase
                    if (n_state != S_WALK) begin
                        n_pend = 1'b0;
                    end
                end
            end

            S_INS: begin
                if (out_free) begin
                    em_valid = 1'b1;
                    n_state  = S_IDLE;
                    if (r_count >= t_count'(TABLE_DEPTH)) begin
                        em_status = ST_FULL;
                    end else begin
                        wr.we    = 1'b1;
                        n_newest = slot_next(r_newest);
                        n_count  = r_count + t_count'(1);
                    end
                end
            end

            S_ONE: begin
                if (out_free) begin
                    em_valid  = 1'b1;
                    em_status = r_st;
                    n_state   = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Result register valid
    always_comb begin
        if (em_valid) begin
            n_ovalid = 1'b1;
        end else if (o_res.ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_newest <= '0;
            r_iss    <= '0;
            r_ci     <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_newest <= n_newest;
            r_iss    <= n_iss;
            r_ci     <= n_ci;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_val   <= n_val;
        r_total <= n_total;
        r_st    <= n_st;
        if (em_valid) begin
            r_ost   <= em_status;
            r_okey  <= em_key;
            r_oval  <= em_val;
            r_otot  <= em_tot;
            r_olast <= em_last;
        end
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.status        = r_ost;
    assign o_res.out_key       = r_okey;
    assign o_res.out_value     = r_oval;
    assign o_res.running_total = r_otot;
    assign o_res.last          = r_olast;

endmodule

/* test/testbench.sv */
module testbench;
    import kft_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 135;

    // One result beat as the table should produce it
    typedef struct {
        t_status status;
        t_key    key;
        t_val    value;
        t_total  total;
        logic    last;
    } t_result;

    // One row of the directed stimulus; 'typed' rows carry their own status
    typedef struct {
        t_cmd    cmd;
        t_key    key;
        t_val    value;
        bit      typed;
        t_status want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    kft_in_if  cmd_if ();
    kft_out_if res_if ();

    keyed_fifo_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // Shadow copy of the record table
    t_key shelf_key [TABLE_DEPTH];
    t_val shelf_val [TABLE_DEPTH];
    int   newest;
    int   held;

    t_result pending [$];
    t_row    plan [$];
    int      mismatches;
    int      cycles;
    int      hold_asks;
    bit      tx_quiet;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    // Slot holding the record 'back' places older than the newest
    function automatic int age_slot(input int back);
        return (newest + TABLE_DEPTH - back) % TABLE_DEPTH;
    endfunction

    function automatic int find_held(input t_key k);
        int s;
        for (int i = 0; i < held; i++) begin
            s = age_slot(i);
            if (shelf_key[s] == k) return s;
        end
        return -1;
    endfunction

    function automatic t_result bare(input t_status st);
        t_result r;
        r = '{st, '0, '0, '0, 1'b1};
        return r;
    endfunction

    // Apply one command to the shadow table and give the beats it should cause
    function automatic void table_step(input t_cmd c, input t_key k, input t_val v,
                                       output t_result res [$]);
        int     hit;
        int     s;
        t_total sum;
        res = {};
        hit = find_held(k);
        case (c)
            CMD_INSERT: begin
                if (hit >= 0) begin
                    res.push_back(bare(ST_DUP));
                end else if (held >= TABLE_DEPTH) begin
                    res.push_back(bare(ST_FULL));
                end else begin
                    newest = (newest + 1) % TABLE_DEPTH;
                    shelf_key[newest] = k;
                    shelf_val[newest] = v;
                    held++;
                    res.push_back(bare(ST_OK));
                end
            end
            CMD_REMOVE: begin
                if (held == 0) begin
                    res.push_back(bare(ST_EMPTY));
                end else begin
                    held--;
                    res.push_back(bare(ST_OK));
                end
            end
            CMD_SEARCH: begin
                if (hit >= 0) begin
                    res.push_back('{ST_OK, shelf_key[hit], shelf_val[hit], '0, 1'b1});
                end else begin
                    res.push_back(bare(ST_NOTFOUND));
                end
            end
            default: begin
                if (held == 0) begin
                    res.push_back(bare(ST_EMPTY));
                end else begin
                    sum = '0;
                    for (int i = 0; i < held; i++) begin
                        s = age_slot(i);
                        sum = sum + t_total'(shelf_val[s]);
                        res.push_back('{ST_OK, shelf_key[s], shelf_val[s], sum,
                                        (i == held - 1)});
                    end
                end
            end
        endcase
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int idle_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one command beat, wait for it to be taken, then book its results
    task automatic offer(input t_cmd c, input t_key k, input t_val v,
                         input bit typed, input t_status want, input bit drain);
        int      gap;
        t_result res [$];
        gap = idle_len(tx_quiet);
        if ($urandom_range(0, 99) < 3) tx_quiet = ~tx_quiet;
        if (drain) begin
            cmd_if.valid <= 1'b0;
            do @(negedge i_clk); while (pending.size() != 0);
        end else if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.command     <= c;
        cmd_if.key         <= k;
        cmd_if.value_cents <= v;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        table_step(c, k, v, res);
        if (typed) begin
            pending.push_back(bare(want));
        end else begin
            foreach (res[i]) pending.push_back(res[i]);
        end
        @(negedge i_clk);
    endtask

    function automatic void add_row(input t_cmd c, input t_key k, input t_val v,
                                    input bit typed, input t_status want);
        t_row r;
        r = '{c, k, v, typed, want};
        plan.push_back(r);
    endfunction

    // Result side: random back-pressure plus one long hold on request
    initial begin
        int hold;
        int len;
        int hold_seen;
        bit rx_quiet;
        hold = 0;
        hold_seen = 0;
        rx_quiet = 1'b0;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                res_if.ready <= 1'b0;
                hold--;
            end else begin
                len = idle_len(rx_quiet);
                if (len > 0) begin
                    res_if.ready <= 1'b0;
                    hold = len - 1;
                end else begin
                    res_if.ready <= 1'b1;
                end
            end
            if ($urandom_range(0, 99) < 3) rx_quiet = ~rx_quiet;
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : check_beat
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending.size() == 0) begin
                report($sformatf("unexpected beat, status %0d", res_if.status));
            end else begin
                want = pending.pop_front();
                if (res_if.status !== want.status)
                    report($sformatf("status %0d, expected %0d",
                                     res_if.status, want.status));
                if (res_if.out_key !== want.key)
                    report($sformatf("out_key %0h, expected %0h",
                                     res_if.out_key, want.key));
                if (res_if.out_value !== want.value)
                    report($sformatf("out_value %0h, expected %0h",
                                     res_if.out_value, want.value));
                if (res_if.running_total !== want.total)
                    report($sformatf("running_total %0h, expected %0h",
                                     res_if.running_total, want.total));
                if (res_if.last !== want.last)
                    report($sformatf("last %0b, expected %0b", res_if.last, want.last));
            end
        end
    end

    // Stimulus
    initial begin
        t_cmd c;
        t_key k;
        t_val v;
        int   r;
        bit   filling;

        cmd_if.valid       = 1'b0;
        cmd_if.command     = CMD_INSERT;
        cmd_if.key         = '0;
        cmd_if.value_cents = '0;
        i_rst_n    = 1'b0;
        mismatches = 0;
        cycles     = 0;
        hold_asks  = 0;
        tx_quiet   = 1'b0;
        newest     = 0;
        held       = 0;

        // Directed: empty table, lone record, fill to the brim, then full-table cases
        add_row(CMD_REMOVE, '0, '0, 1'b1, ST_EMPTY);
        add_row(CMD_LIST,   '0, '0, 1'b1, ST_EMPTY);
        add_row(CMD_SEARCH, '0, '0, 1'b1, ST_NOTFOUND);
        add_row(CMD_INSERT, 32'sh8000_0000, '1, 1'b1, ST_OK);
        add_row(CMD_INSERT, 32'sh8000_0000, 32'd7, 1'b1, ST_DUP);
        add_row(CMD_SEARCH, 32'sh8000_0000, '0, 1'b0, ST_OK);
        add_row(CMD_REMOVE, '0, '0, 1'b1, ST_OK);
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            case (j)
                0:       add_row(CMD_INSERT, 32'sh7FFF_FFFF, '1, 1'b1, ST_OK);
                1:       add_row(CMD_INSERT, '0, '0, 1'b1, ST_OK);
                2:       add_row(CMD_INSERT, -32'sd1, '1, 1'b1, ST_OK);
                default: add_row(CMD_INSERT, t_key'(j * 32'h0101_0101 ^ 32'h5A00_00A5),
                                 t_val'(j * 32'h1111_1111), 1'b1, ST_OK);
            endcase
        end
        // Duplicate wins over full
        add_row(CMD_INSERT, '0, 32'd99, 1'b1, ST_DUP);
        add_row(CMD_INSERT, 32'sd12345, 32'd1, 1'b1, ST_FULL);
        add_row(CMD_LIST,   '0, '0, 1'b0, ST_OK);
        add_row(CMD_SEARCH, 32'sh7FFF_FFFF, '0, 1'b0, ST_OK);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i])
            offer(plan[i].cmd, plan[i].key, plan[i].value, plan[i].typed, plan[i].want, 1'b0);

        // Random: alternate filling and draining phases, keys biased towards held ones
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            filling = ((i / 40) % 2) == 1;
            r = $urandom_range(0, 99);
            if (filling)
                c = (r < 55) ? CMD_INSERT : (r < 65) ? CMD_REMOVE :
                    (r < 85) ? CMD_SEARCH : CMD_LIST;
            else
                c = (r < 20) ? CMD_INSERT : (r < 60) ? CMD_REMOVE :
                    (r < 85) ? CMD_SEARCH : CMD_LIST;
            r = $urandom_range(0, 99);
            if (r < 45 && held > 0)
                k = shelf_key[age_slot($urandom_range(0, held - 1))];
            else if (r < 75)
                k = t_key'(int'($urandom_range(0, 15)) - 8);
            else
                k = t_key'($urandom);
            r = $urandom_range(0, 99);
            v = (r < 10) ? '0 : (r < 20) ? '1 : t_val'($urandom);
            // Long receiver hold while commands keep coming
            if (i == 20) hold_asks++;
            offer(c, k, v, 1'b0, ST_OK, i == 90);
        end
        cmd_if.valid <= 1'b0;

        while (pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* files.f */
design/kft_pkg.sv
design/kft_ifs.sv
design/kft_store.sv
design/keyed_fifo_table.sv
test/testbench.sv
